// ===== rtl/fmp_pkg.sv =====
// package: shared widths, command and state types for the fibonacci mod unit
package fmp_pkg;
  localparam int INDEX_BITS   = 63;
  localparam int MODULUS_BITS = 32;
  localparam int PROD_BITS    = 2 * MODULUS_BITS;
  localparam int BIT_CNT_BITS = $clog2(INDEX_BITS + 1);

  typedef logic [MODULUS_BITS-1:0] word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL,
    ST_WAIT,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    DP_IDLE,
    DP_MUL,
    DP_RED,
    DP_ADD
  } dp_state_t;

  typedef enum logic [1:0] {
    OP_MUL_ACC,
    OP_MUL_BASE
  } op_t;

  typedef struct packed {
    logic load;
    logic start;
    op_t  op;
    logic shift;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic idx_zero;
    logic idx_lsb;
    logic mod_small;
  } status_t;
endpackage

// ===== rtl/fmp_datapath.sv =====
// datapath: matrix registers, one shared multiplier and a bit-serial mod reducer
module fmp_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  fmp_pkg::cmd_t                       cmd,
  input  logic [fmp_pkg::INDEX_BITS-1:0]      index,
  input  logic [fmp_pkg::MODULUS_BITS-1:0]    modulus,
  output fmp_pkg::status_t                    status,
  output logic [fmp_pkg::MODULUS_BITS-1:0]    result
);
  import fmp_pkg::*;

  localparam int RED_CNT_BITS = $clog2(PROD_BITS + 1);

  logic [INDEX_BITS-1:0] n;
  word_t m;
  word_t a00, a01, a10, a11;
  word_t b00, b01, b10, b11;
  word_t r00, r01, r10, r11;
  op_t op;
  dp_state_t dp;
  logic [3:0] term;
  logic [PROD_BITS-1:0] prod;
  logic [MODULUS_BITS:0] rem;
  logic [RED_CNT_BITS-1:0] rcnt;
  word_t first;

  word_t xa, xb;
  logic [MODULUS_BITS+1:0] trial;
  logic [MODULUS_BITS:0] sum;
  word_t sum_red;
  word_t x00, x01, x10, x11;

  assign x00 = (op == OP_MUL_ACC) ? a00 : b00;
  assign x01 = (op == OP_MUL_ACC) ? a01 : b01;
  assign x10 = (op == OP_MUL_ACC) ? a10 : b10;
  assign x11 = (op == OP_MUL_ACC) ? a11 : b11;

  // term order: entry*2 + product, x(row,k)*b(k,col)
  always_comb begin
    case (term[2:0])
      3'd0: begin xa = x00; xb = b00; end
      3'd1: begin xa = x01; xb = b10; end
      3'd2: begin xa = x00; xb = b01; end
      3'd3: begin xa = x01; xb = b11; end
      3'd4: begin xa = x10; xb = b00; end
      3'd5: begin xa = x11; xb = b10; end
      3'd6: begin xa = x10; xb = b01; end
      default: begin xa = x11; xb = b11; end
    endcase
  end

  assign trial = {rem, prod[PROD_BITS-1]} - {1'b0, 1'b0, m};
  assign sum = {1'b0, first} + rem;
  assign sum_red = (sum >= {1'b0, m}) ? word_t'(sum - {1'b0, m}) : sum[MODULUS_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      dp <= DP_IDLE;
    end else begin
      if (cmd.load) begin
        n <= index;
        m <= modulus;
        a00 <= word_t'(1); a01 <= '0; a10 <= '0; a11 <= word_t'(1);
        b00 <= word_t'(1); b01 <= word_t'(1); b10 <= word_t'(1); b11 <= '0;
      end
      if (cmd.shift) n <= n >> 1;
      case (dp)
        DP_IDLE: begin
          if (cmd.start) begin
            op <= cmd.op;
            term <= '0;
            dp <= DP_MUL;
          end
        end
        DP_MUL: begin
          prod <= PROD_BITS'(xa) * PROD_BITS'(xb);
          rem <= '0;
          rcnt <= '0;
          dp <= DP_RED;
        end
        DP_RED: begin
          if (!trial[MODULUS_BITS+1]) rem <= trial[MODULUS_BITS:0];
          else rem <= {rem[MODULUS_BITS-1:0], prod[PROD_BITS-1]};
          prod <= prod << 1;
          rcnt <= rcnt + 1'b1;
          if (rcnt == RED_CNT_BITS'(PROD_BITS - 1)) dp <= DP_ADD;
        end
        default: begin
          if (!term[0]) begin
            first <= rem[MODULUS_BITS-1:0];
          end else begin
            case (term[2:1])
              2'd0: r00 <= sum_red;
              2'd1: r01 <= sum_red;
              2'd2: r10 <= sum_red;
              default: r11 <= sum_red;
            endcase
          end
          if (term == 4'd7) begin
            dp <= DP_IDLE;
            if (op == OP_MUL_ACC) begin
              a00 <= r00; a01 <= r01; a10 <= r10; a11 <= sum_red;
            end else begin
              b00 <= r00; b01 <= r01; b10 <= r10; b11 <= sum_red;
            end
          end else begin
            term <= term + 1'b1;
            dp <= DP_MUL;
          end
        end
      endcase
    end
  end

  assign status.busy = (dp != DP_IDLE);
  assign status.idx_zero = (n == '0);
  assign status.idx_lsb = n[0];
  assign status.mod_small = (m <= word_t'(1));
  assign result = status.mod_small ? '0 : a00;
endmodule

// ===== rtl/fmp_ctrl.sv =====
// controller: square-and-multiply sequencing and handshake
module fmp_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  fmp_pkg::status_t   status,
  output fmp_pkg::cmd_t      cmd
);
  import fmp_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.op = OP_MUL_ACC;
    in_stall = (state != ST_IDLE);
    out_valid = (state == ST_DONE);
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status.idx_zero || status.mod_small) begin
          state_next = ST_DONE;
        end else if (status.idx_lsb) begin
          cmd.start = 1'b1;
          cmd.op = OP_MUL_ACC;
          state_next = ST_MUL;
        end else begin
          cmd.start = 1'b1;
          cmd.op = OP_MUL_BASE;
          state_next = ST_WAIT;
        end
      end
      ST_MUL: begin
        if (!status.busy) begin
          cmd.start = 1'b1;
          cmd.op = OP_MUL_BASE;
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (!status.busy) begin
          cmd.shift = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_DONE: begin
        if (!out_stall) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule

// ===== rtl/fibonacci_mod_matrix_power.sv =====
// top level: fibonacci number mod m by 2x2 matrix power
// per index bit up to the top set bit: a clear bit squares the base matrix, a set
// bit first also multiplies it into the accumulator; each product is 8 terms
// of multiply, reduce and add; run time is set by the shared 64-step mod reducer
// one item at a time; next beat accepted in the cycle after the result beat is taken
// rst is synchronous active high and clears the controller state and the datapath sequencer state
module fibonacci_mod_matrix_power (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [fmp_pkg::INDEX_BITS-1:0]   index,
  input  logic [fmp_pkg::MODULUS_BITS-1:0] modulus,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [fmp_pkg::MODULUS_BITS-1:0] fib_value
);
  import fmp_pkg::*;

  cmd_t cmd;
  status_t status;

  fmp_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .status(status), .cmd(cmd)
  );

  fmp_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .index(index), .modulus(modulus),
    .status(status), .result(fib_value)
  );
endmodule

// ===== tb/sv/fibonacci_mod_matrix_power_checker.sv =====
// checker: watches both channels, predicts fib values and compares results
`timescale 1ns / 1ps
module fibonacci_mod_matrix_power_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic [fmp_pkg::INDEX_BITS-1:0]   index,
  input  logic [fmp_pkg::MODULUS_BITS-1:0] modulus,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic [fmp_pkg::MODULUS_BITS-1:0] fib_value,
  output int                               errors,
  output int                               pending
);
  import fmp_pkg::*;

  word_t fib_q[$];

  function automatic logic [63:0] dot_mod(logic [63:0] a, logic [63:0] b, logic [63:0] c,
                                          logic [63:0] d, logic [63:0] m);
    logic [63:0] s;
    logic [63:0] t;
    s = (a * b) % m;
    t = (c * d) % m;
    s = s + t;
    if (s >= m) s = s - m;
    return s;
  endfunction

  function automatic word_t fib_mod(logic [INDEX_BITS-1:0] n_in, word_t m_in);
    logic [63:0] m;
    logic [63:0] a00, a01, a10, a11, b00, b01, b10, b11, t00, t01, t10, t11;
    logic [INDEX_BITS-1:0] n;
    m = {32'd0, m_in};
    n = n_in;
    if (m <= 1) return '0;
    a00 = 1; a01 = 0; a10 = 0; a11 = 1;
    b00 = 1; b01 = 1; b10 = 1; b11 = 0;
    while (n != 0) begin
      if (n[0]) begin
        t00 = dot_mod(a00, b00, a01, b10, m);
        t01 = dot_mod(a00, b01, a01, b11, m);
        t10 = dot_mod(a10, b00, a11, b10, m);
        t11 = dot_mod(a10, b01, a11, b11, m);
        a00 = t00; a01 = t01; a10 = t10; a11 = t11;
      end
      t00 = dot_mod(b00, b00, b01, b10, m);
      t01 = dot_mod(b00, b01, b01, b11, m);
      t10 = dot_mod(b10, b00, b11, b10, m);
      t11 = dot_mod(b10, b01, b11, b11, m);
      b00 = t00; b01 = t01; b10 = t10; b11 = t11;
      n = n >> 1;
    end
    return word_t'(a00 % m);
  endfunction

  task automatic report(string what, word_t got, word_t want);
    $display("mismatch: %s got %0d want %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  initial begin
    errors = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) fib_q.push_back(fib_mod(index, modulus));
      if (out_valid && !out_stall) begin
        if (fib_q.size() == 0) report("unexpected beat", fib_value, '0);
        else begin
          if (fib_value !== fib_q[0]) report("fib_value", fib_value, fib_q[0]);
          void'(fib_q.pop_front());
        end
      end
      pending = fib_q.size();
    end
  end
endmodule

// ===== tb/sv/fibonacci_mod_matrix_power_tb.sv =====
// testbench top: drives index and modulus beats and gives the verdict
`timescale 1ns / 1ps
module fibonacci_mod_matrix_power_tb;
  import fmp_pkg::*;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [INDEX_BITS-1:0] index;
  word_t modulus;
  logic out_valid;
  logic out_stall;
  word_t fib_value;
  int errors;
  int pending;
  bit quiet;

  fibonacci_mod_matrix_power dut (.*);
  fibonacci_mod_matrix_power_checker chk (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #300ms;
    $display("status: fail");
    $finish;
  end

  // random stall bursts on the result side
  initial begin
    out_stall = 0;
    @(negedge rst);
    forever begin
      repeat ($urandom_range(1, 12)) @(posedge clk);
      if (!quiet && $urandom_range(0, 1)) begin
        out_stall <= 1;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        out_stall <= 0;
      end
    end
  end

  task automatic send(logic [INDEX_BITS-1:0] n, word_t m);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1;
    index <= n;
    modulus <= m;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic logic [INDEX_BITS-1:0] rand_index();
    logic [INDEX_BITS-1:0] v;
    v = INDEX_BITS'({$urandom, $urandom});
    case ($urandom_range(0, 3))
      0: v = v & 63'hff;
      1: v = v & 63'hffff;
      2: v = v >> $urandom_range(0, 62);
      default: ;
    endcase
    return v;
  endfunction

  function automatic word_t rand_mod();
    case ($urandom_range(0, 4))
      0: return word_t'($urandom_range(1, 20));
      1: return 32'hffffffff - $urandom_range(0, 10);
      2: return word_t'($urandom) | 32'h1;
      default: return word_t'($urandom) >> $urandom_range(0, 31);
    endcase
  endfunction

  initial begin
    word_t m;
    rst = 1;
    in_valid = 0;
    index = '0;
    modulus = 32'd1;
    quiet = 0;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send('0, 32'd7);
    send('0, 32'hffffffff);
    send('0, 32'd1);
    send(63'd10, 32'd1);
    send('1, 32'd1);
    send('1, 32'hffffffff);
    send('1, 32'd2);
    send(63'd1, 32'd2);
    send(63'd2, 32'd1000);
    send(63'd46, 32'hffffffff);
    send(63'd47, 32'hffffffff);
    send(63'd90, 32'hffffffff);
    send(63'h4000000000000000, 32'h80000000);
    send(63'h5555555555555555, 32'haaaaaaaa);
    send(63'h2aaaaaaaaaaaaaaa, 32'h55555555);
    send(63'd12345, 32'd3);
    for (int i = 0; i < 100; i++) begin
      if (i >= 85) quiet = 1;
      m = rand_mod();
      if (m == 0) m = 1;
      send(rand_index(), m);
    end
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/fmp_pkg.sv
rtl/fmp_datapath.sv
rtl/fmp_ctrl.sv
rtl/fibonacci_mod_matrix_power.sv
tb/sv/fibonacci_mod_matrix_power_checker.sv
tb/sv/fibonacci_mod_matrix_power_tb.sv
